// ----- hdl/binomial_blur_3x3_stream_top_macros.svh -----
// Assertion macros for the binomial blur stream.
// Used by the modules that carry concurrent assertions; needs i_clk and i_rst_n in scope.
`ifndef BINOMIAL_BLUR_3X3_STREAM_TOP_MACROS_SVH
`define BINOMIAL_BLUR_3X3_STREAM_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Condition that must hold in every cycle out of reset.
`define BB3_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");
// Condition that must hold in the cycle after the trigger.
`define BB3_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error("assertion failed");
`else
`define BB3_ASSERT(lbl, prop)
`define BB3_ASSERT_NEXT(lbl, trig, cons)
`endif

`endif

// ----- hdl/bb3_pkg.sv -----
// Shared constants and types for the binomial blur stream.
// No dependencies; imported by every module of the block but bb3_ram.
package bb3_pkg;

    localparam int PIXEL_BITS  = 16;
    localparam int MAX_COLS    = 4096;
    localparam int COL_BITS    = $clog2(MAX_COLS);
    localparam int ROW_BITS    = 16;
    localparam int WIDTH_BITS  = 13;
    localparam int HEIGHT_BITS = 16;

    // Sum widths along the [1 2 1] x [1 2 1] kernel.
    localparam int PAIR_BITS  = PIXEL_BITS + 1;
    localparam int HSUM_BITS  = PIXEL_BITS + 2;
    localparam int VSUM_BITS  = PIXEL_BITS + 3;
    localparam int TOTAL_BITS = PIXEL_BITS + 4;

    localparam int ROUND_BIAS = 8;
    localparam int NORM_SHIFT = 4;

    // Configuration port.
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 13'd1024;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd1024;
    localparam logic [WIDTH_BITS-1:0]  WIDTH_MIN    = 13'd2;
    localparam logic [WIDTH_BITS-1:0]  WIDTH_MAX    = WIDTH_BITS'(MAX_COLS);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN   = 16'd2;

    // Per-pixel control decided at the input stage.
    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic                col_zero;
        logic                frame_begin;
        logic                produce;
        logic                frame_end;
    } t_stage_ctl;

endpackage

// ----- hdl/bb3_ram.sv -----
// Simple dual-port RAM with registered read data, no reset.
// Generic; holds one line of horizontal or vertical partial sums for the blur.
module bb3_ram #(
    parameter int WIDTH     = 18,
    parameter int ADDR_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [2**ADDR_BITS];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/bb3_ctrl.sv -----
// Input stage: configuration registers, row and column counters, input register.
// Depends on bb3_pkg.
module bb3_ctrl
    import bb3_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_valid,
    input  logic [PIXEL_BITS-1:0]    i_pixel_in,
    input  logic                     i_frame_start,
    input  logic                     i_adv,
    output logic                     o_stall,
    output logic                     o_accept,
    output logic [COL_BITS-1:0]      o_rd_col,
    output logic                     o_a_valid,
    output logic [PIXEL_BITS-1:0]    o_a_pixel,
    output t_stage_ctl               o_a_ctl
);

    logic [WIDTH_BITS-1:0]  r_width;
    logic [HEIGHT_BITS-1:0] r_height;
    logic [COL_BITS-1:0]    r_col, n_col;
    logic [ROW_BITS-1:0]    r_row, n_row;
    logic                   r_a_valid;
    logic [PIXEL_BITS-1:0]  r_a_pixel;
    t_stage_ctl             r_a_ctl, n_a_ctl;

    logic [COL_BITS-1:0]    cur_col;
    logic [ROW_BITS-1:0]    cur_row;
    logic [WIDTH_BITS-1:0]  w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;
    logic                   last_col;
    logic                   last_row;
    logic                   accept;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WIDTH_BITS-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[HEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Position of the incoming pixel and the wrap of the counters.
    always_comb begin
        cur_col = i_frame_start ? '0 : r_col;
        cur_row = i_frame_start ? '0 : r_row;

        w_eff = r_width;
        if (r_width < WIDTH_MIN) begin
            w_eff = WIDTH_MIN;
        end else if (r_width > WIDTH_MAX) begin
            w_eff = WIDTH_MAX;
        end
        h_eff = (r_height < HEIGHT_MIN) ? HEIGHT_MIN : r_height;

        last_col = {1'b0, cur_col} >= (w_eff - WIDTH_BITS'(1));
        last_row = cur_row >= (h_eff - HEIGHT_BITS'(1));

        n_col = last_col ? '0 : cur_col + COL_BITS'(1);
        n_row = cur_row;
        if (last_col) begin
            n_row = last_row ? '0 : cur_row + ROW_BITS'(1);
        end

        n_a_ctl.col         = cur_col;
        n_a_ctl.col_zero    = (cur_col == '0);
        n_a_ctl.frame_begin = (cur_col == '0) && (cur_row == '0);
        n_a_ctl.produce     = (cur_col != '0) && (cur_row != '0);
        n_a_ctl.frame_end   = last_col && last_row;
    end

    // The input register frees up whenever its transaction moves on.
    assign accept  = i_valid && (!r_a_valid || i_adv);
    assign o_stall = r_a_valid && !i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_a_valid <= 1'b1;
            end else if (i_adv) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    // Payload of the input register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_pixel <= i_pixel_in;
            r_a_ctl   <= n_a_ctl;
        end
    end

    assign o_accept  = accept;
    assign o_rd_col  = cur_col;
    assign o_a_valid = r_a_valid;
    assign o_a_pixel = r_a_pixel;
    assign o_a_ctl   = r_a_ctl;

endmodule

// ----- hdl/bb3_filter.sv -----
// Result stage: horizontal sums, line store update and the rounded kernel output.
// Depends on bb3_pkg and the assertion macros header.
`include "binomial_blur_3x3_stream_top_macros.svh"

module bb3_filter
    import bb3_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_a_valid,
    input  logic [PIXEL_BITS-1:0] i_a_pixel,
    input  t_stage_ctl            i_a_ctl,
    input  logic [HSUM_BITS-1:0]  i_rd_a,
    input  logic [VSUM_BITS-1:0]  i_rd_b,
    input  logic                  i_stall,
    output logic                  o_adv,
    output logic                  o_we,
    output logic [COL_BITS-1:0]   o_waddr,
    output logic [HSUM_BITS-1:0]  o_wdata_a,
    output logic [VSUM_BITS-1:0]  o_wdata_b,
    output logic                  o_valid,
    output logic [PIXEL_BITS-1:0] o_pixel_out,
    output logic                  o_frame_end
);

    logic [PIXEL_BITS-1:0] r_prev_pixel;
    logic [PAIR_BITS-1:0]  r_prev_pair;
    logic [COL_BITS-1:0]   r_fill;
    logic                  r_o_valid;
    logic [PIXEL_BITS-1:0] r_o_pixel;
    logic                  r_o_frame_end;

    logic                  adv;
    logic                  stored;
    logic [HSUM_BITS-1:0]  a_eff;
    logic [VSUM_BITS-1:0]  b_eff;
    logic [PAIR_BITS-1:0]  pair;
    logic [HSUM_BITS-1:0]  hsum;
    logic [VSUM_BITS-1:0]  vsum;
    logic [TOTAL_BITS-1:0] total;

    // The stage moves when the result register is empty or being emptied.
    assign adv = i_a_valid && (!r_o_valid || !i_stall);

    // Columns 1 through the fill mark were written in this frame; columns above it read as zero.
    assign stored = (i_a_ctl.col <= r_fill);
    assign a_eff  = stored ? i_rd_a : '0;
    assign b_eff  = stored ? i_rd_b : '0;

    // Kernel arithmetic: horizontal pair and triple, then vertical.
    assign pair  = PAIR_BITS'(r_prev_pixel) + PAIR_BITS'(i_a_pixel);
    assign hsum  = HSUM_BITS'(r_prev_pair) + HSUM_BITS'(pair);
    assign vsum  = VSUM_BITS'(a_eff) + VSUM_BITS'(hsum);
    assign total = TOTAL_BITS'(b_eff) + TOTAL_BITS'(vsum) + TOTAL_BITS'(ROUND_BIAS);

    // Horizontal sums and the fill mark of the line stores.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pixel <= '0;
            r_prev_pair  <= '0;
            r_fill       <= '0;
        end else if (adv) begin
            if (i_a_ctl.col_zero) begin
                r_prev_pixel <= '0;
                r_prev_pair  <= '0;
            end else if (i_a_ctl.produce) begin
                r_prev_pixel <= i_a_pixel;
                r_prev_pair  <= pair;
            end
            if (i_a_ctl.frame_begin) begin
                r_fill <= '0;
            end else if (i_a_ctl.produce && (i_a_ctl.col > r_fill)) begin
                r_fill <= i_a_ctl.col;
            end
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= i_a_ctl.produce;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_pixel     <= total[NORM_SHIFT +: PIXEL_BITS];
            r_o_frame_end <= i_a_ctl.frame_end;
        end
    end

    assign o_adv       = adv;
    assign o_we        = adv && i_a_ctl.produce;
    assign o_waddr     = i_a_ctl.col;
    assign o_wdata_a   = hsum;
    assign o_wdata_b   = vsum;
    assign o_valid     = r_o_valid;
    assign o_pixel_out = r_o_pixel;
    assign o_frame_end = r_o_frame_end;

    // Column zero never reaches the line stores.
    `BB3_ASSERT(a_no_col0_write, !o_we || (o_waddr != '0))
    // A frame begin empties the line stores for the next transactions.
    `BB3_ASSERT_NEXT(a_fill_cleared, adv && i_a_ctl.frame_begin, r_fill == '0)
    // A held result blocks the stage behind it.
    `BB3_ASSERT(a_hold_blocks, !(r_o_valid && i_stall) || !adv)

endmodule

// ----- hdl/binomial_blur_3x3_stream_top.sv -----
// Pipeline: an accepted pixel is held in the input register and moves into the result
// register when that register is empty or being emptied (two register stages).
// Throughput: one pixel per clock while no stall holds the flow; the line store port pair
// (read at input, write at result) sets it, each column touched at most every other pixel.
// Reset (synchronous, active low): counters and sums cleared, width and height back to 1024,
// line stores read as empty through a fill mark; no clearing pass is needed.
module binomial_blur_3x3_stream_top
    import bb3_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [PIXEL_BITS-1:0]    i_pixel_in,
    input  logic                     i_frame_start,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [PIXEL_BITS-1:0]    o_pixel_out,
    output logic                     o_frame_end
);

    logic                  accept;
    logic [COL_BITS-1:0]   rd_col;
    logic                  a_valid;
    logic [PIXEL_BITS-1:0] a_pixel;
    t_stage_ctl            a_ctl;
    logic                  adv;
    logic                  we;
    logic [COL_BITS-1:0]   waddr;
    logic [HSUM_BITS-1:0]  wdata_a;
    logic [VSUM_BITS-1:0]  wdata_b;
    logic [HSUM_BITS-1:0]  rd_a;
    logic [VSUM_BITS-1:0]  rd_b;

    // Input stage and counters.
    bb3_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .i_pixel_in    (i_pixel_in),
        .i_frame_start (i_frame_start),
        .i_adv         (adv),
        .o_stall       (o_stall),
        .o_accept      (accept),
        .o_rd_col      (rd_col),
        .o_a_valid     (a_valid),
        .o_a_pixel     (a_pixel),
        .o_a_ctl       (a_ctl)
    );

    // Line store of horizontal sums from the row above.
    bb3_ram #(
        .WIDTH     (HSUM_BITS),
        .ADDR_BITS (COL_BITS)
    ) u_line_a (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata_a),
        .i_re    (accept),
        .i_raddr (rd_col),
        .o_rdata (rd_a)
    );

    // Line store of vertical partial sums from two rows above.
    bb3_ram #(
        .WIDTH     (VSUM_BITS),
        .ADDR_BITS (COL_BITS)
    ) u_line_b (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata_b),
        .i_re    (accept),
        .i_raddr (rd_col),
        .o_rdata (rd_b)
    );

    // Kernel arithmetic and result register.
    bb3_filter u_filter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_a_valid   (a_valid),
        .i_a_pixel   (a_pixel),
        .i_a_ctl     (a_ctl),
        .i_rd_a      (rd_a),
        .i_rd_b      (rd_b),
        .i_stall     (i_stall),
        .o_adv       (adv),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata_a   (wdata_a),
        .o_wdata_b   (wdata_b),
        .o_valid     (o_valid),
        .o_pixel_out (o_pixel_out),
        .o_frame_end (o_frame_end)
    );

endmodule
